>>> rtl/mt_pkg.sv
package mt_pkg;

    localparam int STATE_WORDS  = 624;
    localparam int IDX_W        = $clog2(STATE_WORDS + 1);
    localparam int TWIST_OFFSET = 397;

    localparam logic [31:0] TWIST_MATRIX = 32'h9908b0df;
    localparam logic [31:0] TEMPER_B     = 32'h9d2c5680;
    localparam logic [31:0] TEMPER_C     = 32'hefc60000;
    localparam logic [31:0] SEED_MULT    = 32'd1812433253;

    localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(STATE_WORDS - 1);
    localparam logic [IDX_W-1:0] WORDS_IDX  = IDX_W'(STATE_WORDS);
    localparam logic [IDX_W-1:0] FAR_START  = IDX_W'(TWIST_OFFSET);
    localparam logic [IDX_W-1:0] NEXT_STEP  = IDX_W'(2);
    localparam logic [IDX_W-1:0] FAR_STEP   = IDX_W'(TWIST_OFFSET + 1);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEED_MUL,
        ST_SEED_ADD,
        ST_TW_PRIME,
        ST_TW_FIRST,
        ST_TW_RUN,
        ST_FETCH,
        ST_READ,
        ST_PUSH
    } mt_state_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        logic [31:0]      data;
    } mem_wr_t;

    function automatic logic [31:0] mt_twist(input logic [31:0] cur,
                                             input logic [31:0] nxt,
                                             input logic [31:0] far);
        logic [31:0] y;
        begin
            y = {cur[31], nxt[30:0]};
            mt_twist = far ^ (y >> 1) ^ (y[0] ? TWIST_MATRIX : 32'd0);
        end
    endfunction

    function automatic logic [31:0] mt_temper(input logic [31:0] w);
        logic [31:0] y;
        begin
            y = w ^ (w >> 11);
            y = y ^ ((y << 7) & TEMPER_B);
            y = y ^ ((y << 15) & TEMPER_C);
            mt_temper = y ^ (y >> 18);
        end
    endfunction

endpackage

>>> rtl/mt19937_generator.sv
// draw: fetch, read, temper and push; a new request waits until the push is done
// a draw that finds all 624 words used first rewrites the state, then fetches
// seed: busy while each word gets a multiply then an add, then the state rewrite
// before the first seed a draw skips the memory and goes straight to the push
// reset leaves the memory uncleared; draws return 0 until the first seed
module mt19937_generator (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_ready,
    input  logic        func,
    input  logic [31:0] seed_value,
    output logic        rsp_valid,
    input  logic        rsp_ready,
    output logic [31:0] random_value
);
    import mt_pkg::*;

    mt_state_t          state_reg, state_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [IDX_W-1:0]   ridx_reg, ridx_next;
    logic               seeded_reg, seeded_next;
    logic               tw_draw_reg, tw_draw_next;
    logic               rsp_valid_reg, rsp_valid_next;
    logic [31:0]        prev_reg, prev_next;
    logic [31:0]        prod_reg, prod_next;
    logic [31:0]        cur_reg, cur_next;
    logic [31:0]        temp_reg, temp_next;
    logic [31:0]        random_value_reg, random_value_next;

    mem_wr_t            wr;
    logic [IDX_W-1:0]   raddr_a, raddr_b;
    logic [31:0]        rdata_a, rdata_b;
    logic [IDX_W-1:0]   addr_a_sum, addr_b_sum;
    logic [31:0]        seed_mix;
    logic [31:0]        seed_word;
    logic               accept;

    mt_state_ram u_ram (
        .clk     (clk),
        .wr      (wr),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    assign req_ready    = (state_reg == ST_IDLE);
    assign accept       = req_valid && req_ready;
    assign rsp_valid    = rsp_valid_reg;
    assign random_value = random_value_reg;

    assign addr_a_sum = idx_reg + NEXT_STEP;
    assign addr_b_sum = idx_reg + FAR_STEP;
    assign seed_mix   = prev_reg ^ (prev_reg >> 30);
    assign seed_word  = prod_reg + 32'(idx_reg);

    always_comb
    begin
        state_next        = state_reg;
        idx_next          = idx_reg;
        ridx_next         = ridx_reg;
        seeded_next       = seeded_reg;
        tw_draw_next      = tw_draw_reg;
        prev_next         = prev_reg;
        prod_next         = prod_reg;
        cur_next          = cur_reg;
        temp_next         = temp_reg;
        random_value_next = random_value_reg;
        rsp_valid_next    = rsp_valid_reg && !rsp_ready;
        wr                = '0;
        raddr_a           = '0;
        raddr_b           = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (!func)
                    begin
                        wr.en       = 1'b1;
                        wr.addr     = '0;
                        wr.data     = seed_value;
                        prev_next   = seed_value;
                        idx_next    = IDX_W'(1);
                        seeded_next = 1'b1;
                        tw_draw_next = 1'b0;
                        state_next  = ST_SEED_MUL;
                    end
                    else if (!seeded_reg)
                    begin
                        temp_next  = '0;
                        state_next = ST_PUSH;
                    end
                    else if (ridx_reg == WORDS_IDX)
                    begin
                        tw_draw_next = 1'b1;
                        state_next   = ST_TW_PRIME;
                    end
                    else
                    begin
                        state_next = ST_FETCH;
                    end
                end
            end
            ST_SEED_MUL:
            begin
                prod_next  = seed_mix * SEED_MULT;
                state_next = ST_SEED_ADD;
            end
            ST_SEED_ADD:
            begin
                wr.en     = 1'b1;
                wr.addr   = idx_reg;
                wr.data   = seed_word;
                prev_next = seed_word;
                if (idx_reg == LAST_IDX)
                begin
                    state_next = ST_TW_PRIME;
                end
                else
                begin
                    idx_next   = idx_reg + IDX_W'(1);
                    state_next = ST_SEED_MUL;
                end
            end
            ST_TW_PRIME:
            begin
                raddr_a    = '0;
                state_next = ST_TW_FIRST;
            end
            ST_TW_FIRST:
            begin
                cur_next   = rdata_a;
                raddr_a    = IDX_W'(1);
                raddr_b    = FAR_START;
                idx_next   = '0;
                state_next = ST_TW_RUN;
            end
            ST_TW_RUN:
            begin
                wr.en    = 1'b1;
                wr.addr  = idx_reg;
                wr.data  = mt_twist(cur_reg, rdata_a, rdata_b);
                cur_next = rdata_a;
                raddr_a  = (addr_a_sum >= WORDS_IDX) ? addr_a_sum - WORDS_IDX : addr_a_sum;
                raddr_b  = (addr_b_sum >= WORDS_IDX) ? addr_b_sum - WORDS_IDX : addr_b_sum;
                if (idx_reg == LAST_IDX)
                begin
                    ridx_next  = '0;
                    state_next = tw_draw_reg ? ST_FETCH : ST_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            ST_FETCH:
            begin
                raddr_a    = ridx_reg;
                state_next = ST_READ;
            end
            ST_READ:
            begin
                temp_next  = mt_temper(rdata_a);
                ridx_next  = ridx_reg + IDX_W'(1);
                state_next = ST_PUSH;
            end
            ST_PUSH:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    random_value_next = temp_reg;
                    rsp_valid_next    = 1'b1;
                    state_next        = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            ridx_reg      <= '0;
            seeded_reg    <= 1'b0;
            tw_draw_reg   <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            ridx_reg      <= ridx_next;
            seeded_reg    <= seeded_next;
            tw_draw_reg   <= tw_draw_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prev_reg         <= prev_next;
        prod_reg         <= prod_next;
        cur_reg          <= cur_next;
        temp_reg         <= temp_next;
        random_value_reg <= random_value_next;
    end

endmodule

>>> rtl/mt_state_ram.sv
module mt_state_ram (
    input  logic                        clk,
    input  mt_pkg::mem_wr_t             wr,
    input  logic [mt_pkg::IDX_W-1:0]    raddr_a,
    input  logic [mt_pkg::IDX_W-1:0]    raddr_b,
    output logic [31:0]                 rdata_a,
    output logic [31:0]                 rdata_b
);
    import mt_pkg::*;

    logic [31:0] mem [STATE_WORDS];

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

>>> test/mt_tb_pkg.sv
package mt_tb_pkg;

    typedef enum logic {
        OP_SEED = 1'b0,
        OP_DRAW = 1'b1
    } mt_op_e;

endpackage

>>> test/mt_checker.sv
module mt_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    input  logic        req_ready,
    input  logic        func,
    input  logic [31:0] seed_value,
    input  logic        rsp_valid,
    input  logic        rsp_ready,
    input  logic [31:0] random_value,
    output int          mismatches,
    output int          pending_draws
);
    timeunit 1ns;
    timeprecision 1ps;

    import mt_pkg::*;
    import mt_tb_pkg::*;

    logic [31:0]      mt_words [STATE_WORDS];
    logic [IDX_W-1:0] read_idx;
    logic [IDX_W-1:0] words_left;
    logic [31:0]      draws_due [$];
    int               draw_count;

    function automatic void twist_all();
        logic [31:0] mixed;
        logic [31:0] far_word;
        for (int i = 0; i < STATE_WORDS; i++)
        begin
            mixed    = {mt_words[i][31], mt_words[(i + 1) % STATE_WORDS][30:0]};
            far_word = mt_words[(i + TWIST_OFFSET) % STATE_WORDS];
            mt_words[i] = far_word ^ {1'b0, mixed[31:1]} ^ (mixed[0] ? TWIST_MATRIX : 32'd0);
        end
        read_idx   = '0;
        words_left = WORDS_IDX;
    endfunction

    function automatic void fill_from_seed(input logic [31:0] seed);
        logic [31:0] prev;
        mt_words[0] = seed;
        for (int i = 1; i < STATE_WORDS; i++)
        begin
            prev        = mt_words[i - 1];
            mt_words[i] = SEED_MULT * (prev ^ {30'd0, prev[31:30]}) + 32'(i);
        end
    endfunction

    function automatic logic [31:0] tempered(input logic [31:0] raw);
        logic [31:0] t;
        t = raw ^ {11'd0, raw[31:11]};
        t = t ^ ({t[24:0], 7'd0} & TEMPER_B);
        t = t ^ ({t[16:0], 15'd0} & TEMPER_C);
        return t ^ {18'd0, t[31:18]};
    endfunction

    function automatic logic [31:0] next_draw();
        logic [31:0] raw;
        if (words_left == '0 || read_idx >= WORDS_IDX)
            twist_all();
        words_left = words_left - 1'b1;
        raw        = mt_words[read_idx];
        read_idx   = read_idx + 1'b1;
        return tempered(raw);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        logic [31:0] want;
        if (!rst_n)
        begin
            foreach (mt_words[i])
                mt_words[i] = '0;
            read_idx      = '0;
            words_left    = '0;
            draws_due.delete();
            mismatches    = 0;
            draw_count    = 0;
            pending_draws = 0;
        end
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (draws_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("random_value %08h arrived with no draw pending", random_value);
                end
                else
                begin
                    want = draws_due.pop_front();
                    if (random_value !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("draw %0d: random_value expected %08h, got %08h",
                                     draw_count, want, random_value);
                    end
                    draw_count++;
                end
            end
            if (req_valid && req_ready)
            begin
                if (func == OP_SEED)
                begin
                    fill_from_seed(seed_value);
                    twist_all();
                end
                else
                    draws_due.push_back(next_draw());
            end
            pending_draws = draws_due.size();
        end
    end

endmodule

>>> test/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mt_tb_pkg::*;

    localparam int ITEM_TARGET = 1650;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        req_valid;
    logic        req_ready;
    logic        func;
    logic [31:0] seed_value;
    logic        rsp_valid;
    logic        rsp_ready;
    logic [31:0] random_value;
    int          mismatches;
    int          pending_draws;

    int items_sent = 0;
    bit tx_calm = 1'b0;

    mt19937_generator dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_ready    (req_ready),
        .func         (func),
        .seed_value   (seed_value),
        .rsp_valid    (rsp_valid),
        .rsp_ready    (rsp_ready),
        .random_value (random_value)
    );

    mt_checker u_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_ready     (req_ready),
        .func          (func),
        .seed_value    (seed_value),
        .rsp_valid     (rsp_valid),
        .rsp_ready     (rsp_ready),
        .random_value  (random_value),
        .mismatches    (mismatches),
        .pending_draws (pending_draws)
    );

    always #5 clk = ~clk;

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        #8_000_000;
        $display("** mt19937_generator: FAILED **");
        $finish;
    end

    task automatic offer(input mt_op_e op, input logic [31:0] seed);
        int gap;
        if (items_sent % 64 == 0)
            tx_calm = ($urandom_range(0, 3) == 0);
        gap = tx_calm ? 0 : $urandom_range(0, 15);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid  <= 1'b1;
        func       <= op;
        seed_value <= seed;
        do
            @(posedge clk);
        while (!(req_valid && req_ready));
        items_sent++;
    endtask

    task automatic offer_draws(input int count);
        repeat (count)
            offer(OP_DRAW, $urandom());
    endtask

    function automatic logic [31:0] pick_seed();
        case ($urandom_range(0, 7))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    // result side: random stalls, calm stretches and two long hold-offs
    initial
    begin
        int stall;
        int taken;
        bit rx_calm;
        rsp_ready <= 1'b0;
        taken   = 0;
        rx_calm = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (taken % 64 == 0)
                rx_calm = ($urandom_range(0, 3) == 0);
            stall = rx_calm ? 0 : $urandom_range(0, 15);
            if (taken == 100 || taken == 1000)
                stall = 400;
            if (stall > 0)
            begin
                rsp_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ready <= 1'b1;
            do
                @(posedge clk);
            while (!(rsp_valid && rsp_ready));
            taken++;
        end
    end

    initial
    begin
        int run;
        req_valid  <= 1'b0;
        func       <= OP_DRAW;
        seed_value <= '0;
        wait (rst_n);
        @(posedge clk);

        // draws before the first seed
        offer(OP_DRAW, 32'h0000_0000);
        offer(OP_DRAW, 32'hFFFF_FFFF);
        offer(OP_DRAW, $urandom());
        offer(OP_SEED, 32'h0000_0000);
        offer_draws(2);
        offer(OP_SEED, 32'hFFFF_FFFF);
        offer_draws(2);
        offer(OP_SEED, 32'd5489);
        offer_draws(3);
        // back-to-back seeds
        offer(OP_SEED, 32'h8000_0000);
        offer(OP_SEED, 32'h7FFF_FFFF);
        offer_draws(2);
        offer(OP_SEED, 32'h0000_0001);
        offer_draws(1);

        // one long run crosses the refill point twice
        offer(OP_SEED, $urandom());
        offer_draws($urandom_range(1250, 1300));
        while (items_sent < ITEM_TARGET)
        begin
            offer(OP_SEED, pick_seed());
            case ($urandom_range(0, 7))
                0:       run = 0;
                default: run = $urandom_range(1, 40);
            endcase
            offer_draws(run);
        end
        req_valid <= 1'b0;

        @(negedge clk);
        while (pending_draws != 0)
            @(negedge clk);
        repeat (2000) @(negedge clk);
        if (mismatches == 0)
            $display("** mt19937_generator: PASSED **");
        else
            $display("** mt19937_generator: FAILED **");
        $finish;
    end

endmodule

>>> files.f
rtl/mt_pkg.sv
rtl/mt_state_ram.sv
rtl/mt19937_generator.sv
test/mt_tb_pkg.sv
test/mt_checker.sv
test/tb.sv
